// ===== rtl/core/tilq_pkg.sv =====
`default_nettype none
package tilq_pkg;

    localparam int VAL_W   = 32;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W   = 33;          // magnitude of a 33-bit difference
    localparam int NUM_W   = 100;         // product of three magnitudes
    localparam int UNIT_W  = 102;         // shared adder width
    localparam int STEP_W  = 7;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_QUAD   = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZDIV = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [MAG_W-1:0] t_diff;
    typedef logic [MAG_W-1:0] t_mag;

    function automatic t_diff sub33(input t_val a, input t_val b);
        return $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
    endfunction

    function automatic t_mag mag33(input t_diff v);
        t_diff n;
        n = -v;
        return v[MAG_W-1] ? t_mag'(n) : t_mag'(v);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tilq_if.sv =====
`default_nettype none
interface tilq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [tilq_pkg::IDX_W-1:0]            point_index;
    logic signed [tilq_pkg::VAL_W-1:0]     point_x;
    logic signed [tilq_pkg::VAL_W-1:0]     point_y;
    logic signed [tilq_pkg::VAL_W-1:0]     query_x;

    modport source (output valid, kind, point_index, point_x, point_y, query_x,
                    input ready);
    modport sink   (input valid, kind, point_index, point_x, point_y, query_x,
                    output ready);
endinterface

interface tilq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tilq_pkg::VAL_W-1:0]     value;
    logic [tilq_pkg::STAT_W-1:0]           status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/table_interpolator_linear_quadratic_core.sv =====
`default_nettype none
// channel   dir  handshake     payload
// i_in      in   valid/ready   kind, point_index, point_x, point_y, query_x
// o_out     out  valid/ready   value, status
// i_cfg_*   in   write enable  i_cfg_idx selects interp_mode or point_count
//
// a load writes its table entry; a query runs a binary search and a window fetch,
// then evaluates each Lagrange term (one term linear, none at zero spacing, three
// quadratic) and posts the result, all on one shared 102-bit add/subtract unit
// that runs the shift-add multiplies and the restoring divide one bit a step.
// sync active-low reset clears control only; the table needs no clearing.
// a finished result waits in the output register; new beats are taken meanwhile.
module table_interpolator_linear_quadratic_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [tilq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [tilq_pkg::CNT_W-1:0]        i_cfg_data,
    tilq_in_if.sink                          i_in,
    tilq_out_if.source                       o_out
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW0 = $clog2(TABLE_DEPTH + 1);
    localparam int CW  = (CW0 > tilq_pkg::CNT_W) ? CW0 : tilq_pkg::CNT_W;
    localparam int W   = tilq_pkg::NUM_W;
    localparam int UW  = tilq_pkg::UNIT_W;
    localparam int MB  = tilq_pkg::MAG_W;
    localparam int SW  = tilq_pkg::STEP_W;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SRCH_RD  = 14'b00000000000010,
        S_SRCH_CMP = 14'b00000000000100,
        S_WIN_RD   = 14'b00000000001000,
        S_WIN_LD   = 14'b00000000010000,
        S_EVAL     = 14'b00000000100000,
        S_SETUP    = 14'b00000001000000,
        S_MUL      = 14'b00000010000000,
        S_DIV      = 14'b00000100000000,
        S_RCMP     = 14'b00001000000000,
        S_RINC     = 14'b00010000000000,
        S_ACC      = 14'b00100000000000,
        S_DONE     = 14'b01000000000000,
        S_SPARE    = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [2*tilq_pkg::VAL_W-1:0] mem [TABLE_DEPTH];
    logic [2*tilq_pkg::VAL_W-1:0] r_rd;
    logic [AW-1:0]                rd_addr;

    logic                    r_mode;
    logic [tilq_pkg::CNT_W-1:0] r_pc;
    tilq_pkg::t_val          r_q;
    logic [CW-1:0]           r_lo, r_hi, r_mid, r_n;
    logic                    r_quad;
    logic [1:0]              r_k;
    tilq_pkg::t_val          r_cx [3];
    tilq_pkg::t_val          r_cy [3];
    tilq_pkg::t_mag          r_m3, r_d1, r_d2, r_mplier;
    logic                    r_neg;
    logic [W-1:0]            r_mcand, r_acc, r_num, r_den;
    logic [SW-1:0]           r_cnt;
    logic [1:0]              r_ph;
    logic                    r_rnd;
    logic [UW-1:0]           r_sum;
    logic                    r_zdiv;
    logic                    r_ovalid;
    tilq_pkg::t_val          r_oval;
    logic [tilq_pkg::STAT_W-1:0] r_ostat;

    // shared adder
    logic [UW-1:0] u_a, u_b, u_res;
    logic          u_sub;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid, span, widx, wsum, pc_ext, n_clamp, slot;
    logic          in_acc, load_acc, query_acc;
    logic [W-1:0]  rem_sh;
    logic          qbit;

    tilq_pkg::t_val xk, xa, xb, yk;
    tilq_pkg::t_diff na, nb, da, db, dx, dy;
    tilq_pkg::t_mag  s_m1, s_m2, s_m3, s_d1, s_d2;
    logic            s_neg;
    logic            pos_ovf, neg_ovf;

    assign in_acc    = i_in.valid && i_in.ready;
    assign load_acc  = in_acc && (i_in.kind == tilq_pkg::KIND_LOAD);
    assign query_acc = in_acc && (i_in.kind == tilq_pkg::KIND_QUERY);
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid  = r_ovalid;
    assign o_out.value  = r_oval;
    assign o_out.status = r_ostat;

    assign slot    = CW'(i_in.point_index);
    assign pc_ext  = CW'(r_pc);
    assign n_clamp = (pc_ext < CW'(2)) ? CW'(2)
                   : ((pc_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : pc_ext);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign span    = r_hi - r_lo;
    assign wsum    = r_lo + CW'(r_k);
    assign widx    = (wsum < r_n) ? wsum : (r_n - CW'(1));
    assign rd_addr = (r_state == S_WIN_RD) ? widx[AW-1:0] : mid[AW-1:0];
    assign rem_sh  = {r_acc[W-2:0], r_num[W-1]};

    always_ff @(posedge i_clk) begin
        if (load_acc && (slot < CW'(TABLE_DEPTH))) begin
            mem[slot[AW-1:0]] <= {i_in.point_x, i_in.point_y};
        end
        if (r_state == S_SRCH_RD || r_state == S_WIN_RD) begin
            r_rd <= mem[rd_addr];
        end
    end

    // operands of one Lagrange term (or the single linear term)
    always_comb begin
        xk = r_cx[0];
        xa = r_cx[1];
        xb = r_cx[2];
        yk = r_cy[0];
        unique case (r_k)
            2'd1: begin
                xk = r_cx[1]; xa = r_cx[2]; xb = r_cx[0]; yk = r_cy[1];
            end
            2'd2: begin
                xk = r_cx[2]; xa = r_cx[0]; xb = r_cx[1]; yk = r_cy[2];
            end
            default: begin
                xk = r_cx[0]; xa = r_cx[1]; xb = r_cx[2]; yk = r_cy[0];
            end
        endcase
        na = tilq_pkg::sub33(r_q, xa);
        nb = tilq_pkg::sub33(r_q, xb);
        da = tilq_pkg::sub33(xk, xa);
        db = tilq_pkg::sub33(xk, xb);
        dx = tilq_pkg::sub33(r_cx[1], r_cx[0]);
        dy = tilq_pkg::sub33(r_cy[1], r_cy[0]);
        if (r_quad) begin
            s_m1  = tilq_pkg::mag33(na);
            s_m2  = tilq_pkg::mag33(nb);
            s_m3  = tilq_pkg::mag33({yk[tilq_pkg::VAL_W-1], yk});
            s_d1  = tilq_pkg::mag33(da);
            s_d2  = tilq_pkg::mag33(db);
            s_neg = na[MB-1] ^ nb[MB-1] ^ yk[tilq_pkg::VAL_W-1] ^ da[MB-1] ^ db[MB-1];
        end else begin
            na    = tilq_pkg::sub33(r_q, r_cx[0]);
            s_m1  = tilq_pkg::mag33(na);
            s_m2  = tilq_pkg::mag33(dy);
            s_m3  = MB'(1);
            s_d1  = tilq_pkg::mag33(dx);
            s_d2  = MB'(1);
            s_neg = na[MB-1] ^ dy[MB-1];
        end
    end

    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                u_a = UW'({r_acc[W-2:0], 1'b0});
                u_b = r_mplier[MB-1] ? UW'(r_mcand) : '0;
            end
            S_DIV: begin
                u_a   = UW'(rem_sh);
                u_b   = UW'(r_den);
                u_sub = 1'b1;
            end
            S_RCMP: begin
                u_a   = UW'({r_acc, 1'b0});
                u_b   = UW'(r_den);
                u_sub = 1'b1;
            end
            S_RINC: begin
                u_a = UW'(r_num);
                u_b = UW'(r_rnd);
            end
            S_ACC: begin
                u_a   = r_sum;
                u_b   = UW'(r_num);
                u_sub = r_neg;
            end
            default: begin
                u_a   = '0;
                u_b   = '0;
                u_sub = 1'b0;
            end
        endcase
        u_res = u_a + (u_sub ? ~u_b : u_b) + UW'(u_sub);
    end

    assign qbit    = !u_res[UW-1];
    assign pos_ovf = !r_sum[UW-1] && (|r_sum[UW-2:tilq_pkg::VAL_W-1]);
    assign neg_ovf = r_sum[UW-1] && !(&r_sum[UW-2:tilq_pkg::VAL_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= tilq_pkg::MODE_LINEAR;
            r_pc     <= tilq_pkg::CNT_W'(2);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tilq_pkg::CFG_MODE) begin
                    r_mode <= i_cfg_data[0];
                end else if (i_cfg_idx == tilq_pkg::CFG_COUNT) begin
                    r_pc <= i_cfg_data;
                end
            end
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (query_acc) begin
                        r_q     <= i_in.query_x;
                        r_n     <= n_clamp;
                        r_quad  <= (r_mode == tilq_pkg::MODE_QUAD) && (n_clamp >= CW'(3));
                        r_lo    <= '0;
                        r_hi    <= n_clamp - CW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (span > CW'(1)) begin
                        r_mid   <= mid;
                        r_state <= S_SRCH_CMP;
                    end else begin
                        // window base: quadratic steps back one point except at the start
                        if (r_quad && r_lo != '0) begin
                            r_lo <= r_lo - CW'(1);
                        end
                        r_k     <= 2'd0;
                        r_state <= S_WIN_RD;
                    end
                end
                S_SRCH_CMP: begin
                    if ($signed(r_rd[2*tilq_pkg::VAL_W-1:tilq_pkg::VAL_W]) > r_q) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid;
                    end
                    r_state <= S_SRCH_RD;
                end
                S_WIN_RD: begin
                    r_state <= S_WIN_LD;
                end
                S_WIN_LD: begin
                    r_cx[r_k] <= r_rd[2*tilq_pkg::VAL_W-1:tilq_pkg::VAL_W];
                    r_cy[r_k] <= r_rd[tilq_pkg::VAL_W-1:0];
                    if (r_k == 2'd2) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_WIN_RD;
                    end
                end
                S_EVAL: begin
                    r_k    <= 2'd0;
                    r_zdiv <= 1'b0;
                    if (r_quad) begin
                        r_sum <= '0;
                        if (r_cx[0] == r_cx[1] || r_cx[0] == r_cx[2] || r_cx[1] == r_cx[2]) begin
                            r_zdiv  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end else begin
                        r_sum <= UW'(r_cy[0]);
                        // zero or negative spacing keeps the left ordinate
                        if (!dx[MB-1] && dx != '0) begin
                            r_state <= S_SETUP;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SETUP: begin
                    r_mcand  <= W'(s_m1);
                    r_mplier <= s_m2;
                    r_m3     <= s_m3;
                    r_d1     <= s_d1;
                    r_d2     <= s_d2;
                    r_neg    <= s_neg;
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_ph     <= 2'd0;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_acc    <= u_res[W-1:0];
                    r_mplier <= {r_mplier[MB-2:0], 1'b0};
                    r_cnt    <= r_cnt + SW'(1);
                    if (r_cnt == SW'(MB - 1)) begin
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_ph  <= r_ph + 2'd1;
                        unique case (r_ph)
                            2'd0: begin
                                r_mcand  <= u_res[W-1:0];
                                r_mplier <= r_m3;
                            end
                            2'd1: begin
                                r_num    <= u_res[W-1:0];
                                r_mcand  <= W'(r_d1);
                                r_mplier <= r_d2;
                            end
                            default: begin
                                r_den   <= u_res[W-1:0];
                                r_state <= S_DIV;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_acc <= qbit ? u_res[W-1:0] : rem_sh;
                    r_num <= {r_num[W-2:0], qbit};
                    r_cnt <= r_cnt + SW'(1);
                    if (r_cnt == SW'(W - 1)) begin
                        r_state <= S_RCMP;
                    end
                end
                S_RCMP: begin
                    r_rnd   <= qbit;
                    r_state <= S_RINC;
                end
                S_RINC: begin
                    r_num   <= u_res[W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= u_res;
                    r_k   <= r_k + 2'd1;
                    if (!r_quad || r_k == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_zdiv) begin
                            r_oval  <= '0;
                            r_ostat <= tilq_pkg::ST_ZDIV;
                        end else if (pos_ovf) begin
                            r_oval  <= 32'sh7FFF_FFFF;
                            r_ostat <= tilq_pkg::ST_SAT;
                        end else if (neg_ovf) begin
                            r_oval  <= 32'sh8000_0000;
                            r_ostat <= tilq_pkg::ST_SAT;
                        end else begin
                            r_oval  <= r_sum[tilq_pkg::VAL_W-1:0];
                            r_ostat <= tilq_pkg::ST_OK;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_query_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |=> (r_state == S_SRCH_RD))
        else $error("query did not start the search");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("divide with zero divisor");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CMP) |-> (r_lo < r_mid && r_mid < r_hi))
        else $error("search bounds out of order");

    a_done_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result overwritten before taken");

endmodule
`default_nettype wire
